// ----- rtl/two_class_priority_queue_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Two-class priority queue unit: assertion macros
// Shared concurrent assertion forms for the queue unit's modules.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Whenever the antecedent holds at a clock edge, the consequent holds too.
`define TCPQ_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The condition never holds at a clock edge outside reset.
`define TCPQ_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

// ----- rtl/tcpq_pkg.sv -----
// ----------------------------------------------------------------------------
// Two-class priority queue package
// Sizes, codes, payload types and helpers shared by the queue unit.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int KEY_BITS    = 7;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = 5;
    localparam int ENTRY_W     = TAG_BITS + KEY_BITS;

    localparam logic [KEY_BITS-1:0] THRESHOLD_RESET = 7'd60;

    // Result buffer between the queue logic and the output channel.
    localparam int RES_DEPTH = 3;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 2;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 1'b0;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_SERVE = 1'b1;

    localparam logic CLASS_NORMAL    = 1'b0;
    localparam logic CLASS_PREFERRED = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_SERVED  = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_DROPPED = 2'd3
    } status_t;

    typedef struct packed {
        logic                kind;
        logic [15:0]         entry_tag;
        logic [KEY_BITS-1:0] class_key;
    } in_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [15:0]         served_tag;
        logic [KEY_BITS-1:0] served_key;
        logic                served_class;
        logic [FILL_W-1:0]   preferred_count;
        logic [FILL_W-1:0]   normal_count;
    } out_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [KEY_BITS-1:0] key;
    } entry_t;

    typedef struct packed {
        logic valid;
        out_t word;
    } res_push_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [RES_PTR_W-1:0] res_ptr_inc(input logic [RES_PTR_W-1:0] p);
        return (p == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ----- rtl/tcpq_ram.sv -----
// ----------------------------------------------------------------------------
// Two-class priority queue RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcpq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 23,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tcpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Two-class priority queue control
// Head, tail and fill bookkeeping for both queues, the store RAMs and the
// result stage that collects read data in the cycle after an item is taken.
// ----------------------------------------------------------------------------
`include "two_class_priority_queue_unit_macros.svh"

module tcpq_ctrl (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  tcpq_pkg::in_t                            s_data,
    input  logic [tcpq_pkg::KEY_BITS-1:0]            threshold,
    input  logic [tcpq_pkg::RES_CNT_W-1:0]           buf_count,
    output tcpq_pkg::res_push_t                      push
);

    logic [tcpq_pkg::PTR_W-1:0]  pref_head_reg, pref_head_next;
    logic [tcpq_pkg::PTR_W-1:0]  pref_tail_reg, pref_tail_next;
    logic [tcpq_pkg::FILL_W-1:0] pref_fill_reg, pref_fill_next;
    logic [tcpq_pkg::PTR_W-1:0]  norm_head_reg, norm_head_next;
    logic [tcpq_pkg::PTR_W-1:0]  norm_tail_reg, norm_tail_next;
    logic [tcpq_pkg::FILL_W-1:0] norm_fill_reg, norm_fill_next;

    logic                        st1_valid_reg, st1_valid_next;
    tcpq_pkg::status_t           st1_status_reg, st1_status_next;
    logic                        st1_class_reg, st1_class_next;
    logic [tcpq_pkg::FILL_W-1:0] st1_pref_cnt_reg;
    logic [tcpq_pkg::FILL_W-1:0] st1_norm_cnt_reg;

    logic                        s_fire;
    logic                        to_pref;
    logic                        pref_we, norm_we, pref_re, norm_re;
    tcpq_pkg::entry_t            wr_entry;
    tcpq_pkg::entry_t            pref_rd, norm_rd, served;

    // The result buffer holds three words; an item is taken only when the
    // word it will produce is sure to find room.
    assign s_ready = ({1'b0, buf_count} + {2'b00, st1_valid_reg})
                     < 3'(tcpq_pkg::RES_DEPTH);
    assign s_fire  = s_valid & s_ready;
    assign to_pref = s_data.class_key >= threshold;

    assign wr_entry.tag = s_data.entry_tag[tcpq_pkg::TAG_BITS-1:0];
    assign wr_entry.key = s_data.class_key;

    always_comb begin
        pref_head_next  = pref_head_reg;
        pref_tail_next  = pref_tail_reg;
        pref_fill_next  = pref_fill_reg;
        norm_head_next  = norm_head_reg;
        norm_tail_next  = norm_tail_reg;
        norm_fill_next  = norm_fill_reg;
        pref_we         = 1'b0;
        norm_we         = 1'b0;
        pref_re         = 1'b0;
        norm_re         = 1'b0;
        st1_valid_next  = s_fire;
        st1_status_next = st1_status_reg;
        st1_class_next  = st1_class_reg;
        if (s_fire) begin
            st1_class_next = tcpq_pkg::CLASS_NORMAL;
            if (s_data.kind == tcpq_pkg::KIND_ADD) begin
                st1_status_next = tcpq_pkg::ST_DROPPED;
                if (to_pref) begin
                    if (pref_fill_reg != tcpq_pkg::FILL_W'(tcpq_pkg::QUEUE_DEPTH)) begin
                        pref_we         = 1'b1;
                        pref_tail_next  = tcpq_pkg::ptr_inc(pref_tail_reg);
                        pref_fill_next  = pref_fill_reg + 1'b1;
                        st1_status_next = tcpq_pkg::ST_ADDED;
                    end
                end else begin
                    if (norm_fill_reg != tcpq_pkg::FILL_W'(tcpq_pkg::QUEUE_DEPTH)) begin
                        norm_we         = 1'b1;
                        norm_tail_next  = tcpq_pkg::ptr_inc(norm_tail_reg);
                        norm_fill_next  = norm_fill_reg + 1'b1;
                        st1_status_next = tcpq_pkg::ST_ADDED;
                    end
                end
            end else begin
                if (pref_fill_reg != '0) begin
                    pref_re         = 1'b1;
                    pref_head_next  = tcpq_pkg::ptr_inc(pref_head_reg);
                    pref_fill_next  = pref_fill_reg - 1'b1;
                    st1_status_next = tcpq_pkg::ST_SERVED;
                    st1_class_next  = tcpq_pkg::CLASS_PREFERRED;
                end else if (norm_fill_reg != '0) begin
                    norm_re         = 1'b1;
                    norm_head_next  = tcpq_pkg::ptr_inc(norm_head_reg);
                    norm_fill_next  = norm_fill_reg - 1'b1;
                    st1_status_next = tcpq_pkg::ST_SERVED;
                end else begin
                    st1_status_next = tcpq_pkg::ST_EMPTY;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pref_head_reg <= '0;
            pref_tail_reg <= '0;
            pref_fill_reg <= '0;
            norm_head_reg <= '0;
            norm_tail_reg <= '0;
            norm_fill_reg <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            pref_head_reg <= pref_head_next;
            pref_tail_reg <= pref_tail_next;
            pref_fill_reg <= pref_fill_next;
            norm_head_reg <= norm_head_next;
            norm_tail_reg <= norm_tail_next;
            norm_fill_reg <= norm_fill_next;
            st1_valid_reg <= st1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        st1_status_reg <= st1_status_next;
        st1_class_reg  <= st1_class_next;
        if (s_fire) begin
            st1_pref_cnt_reg <= pref_fill_next;
            st1_norm_cnt_reg <= norm_fill_next;
        end
    end

    tcpq_ram #(
        .DEPTH (tcpq_pkg::QUEUE_DEPTH),
        .WIDTH (tcpq_pkg::ENTRY_W)
    ) u_pref_ram (
        .aclk  (aclk),
        .we    (pref_we),
        .waddr (pref_tail_reg),
        .wdata (wr_entry),
        .re    (pref_re),
        .raddr (pref_head_reg),
        .rdata (pref_rd)
    );

    tcpq_ram #(
        .DEPTH (tcpq_pkg::QUEUE_DEPTH),
        .WIDTH (tcpq_pkg::ENTRY_W)
    ) u_norm_ram (
        .aclk  (aclk),
        .we    (norm_we),
        .waddr (norm_tail_reg),
        .wdata (wr_entry),
        .re    (norm_re),
        .raddr (norm_head_reg),
        .rdata (norm_rd)
    );

    // Read data is valid in the stage after the serve was taken.
    always_comb begin
        served = '0;
        if (st1_status_reg == tcpq_pkg::ST_SERVED) begin
            served = (st1_class_reg == tcpq_pkg::CLASS_PREFERRED) ? pref_rd : norm_rd;
        end
    end

    assign push.valid                = st1_valid_reg;
    assign push.word.status          = st1_status_reg;
    assign push.word.served_tag      = served.tag;
    assign push.word.served_key      = served.key;
    assign push.word.served_class    = st1_class_reg;
    assign push.word.preferred_count = st1_pref_cnt_reg;
    assign push.word.normal_count    = st1_norm_cnt_reg;

    `TCPQ_ASSERT_NEVER(a_pref_fill_range, aclk, aresetn,
        pref_fill_reg > tcpq_pkg::FILL_W'(tcpq_pkg::QUEUE_DEPTH), "preferred fill overflow")
    `TCPQ_ASSERT_NEVER(a_norm_fill_range, aclk, aresetn,
        norm_fill_reg > tcpq_pkg::FILL_W'(tcpq_pkg::QUEUE_DEPTH), "normal fill overflow")
    `TCPQ_ASSERT_IMPLIES(a_strict_priority, aclk, aresetn,
        st1_valid_reg && st1_status_reg == tcpq_pkg::ST_SERVED
            && st1_class_reg == tcpq_pkg::CLASS_NORMAL,
        st1_pref_cnt_reg == '0, "normal entry served while preferred queue held entries")

endmodule

// ----- rtl/tcpq_res_buf.sv -----
// ----------------------------------------------------------------------------
// Two-class priority queue result buffer
// Three-word queue that decouples the result channel from the queue logic.
// ----------------------------------------------------------------------------
`include "two_class_priority_queue_unit_macros.svh"

module tcpq_res_buf (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tcpq_pkg::res_push_t            push,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tcpq_pkg::out_t                 m_data,
    output logic [tcpq_pkg::RES_CNT_W-1:0] count
);

    tcpq_pkg::out_t                 buf_reg [tcpq_pkg::RES_DEPTH];
    logic [tcpq_pkg::RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tcpq_pkg::RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tcpq_pkg::RES_CNT_W-1:0] count_reg, count_next;
    logic                           pop;

    assign m_valid = count_reg != '0;
    assign m_data  = buf_reg[rd_ptr_reg];
    assign pop     = m_valid & m_ready;
    assign count   = count_reg;

    always_comb begin
        wr_ptr_next = push.valid ? tcpq_pkg::res_ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? tcpq_pkg::res_ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push.valid} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            buf_reg[wr_ptr_reg] <= push.word;
        end
    end

    `TCPQ_ASSERT_NEVER(a_buf_count_range, aclk, aresetn,
        count_reg > tcpq_pkg::RES_CNT_W'(tcpq_pkg::RES_DEPTH), "result buffer count overflow")
    `TCPQ_ASSERT_IMPLIES(a_buf_no_overrun, aclk, aresetn,
        push.valid, count_reg != tcpq_pkg::RES_CNT_W'(tcpq_pkg::RES_DEPTH),
        "word pushed into a full result buffer")

endmodule

// ----- rtl/two_class_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Two-class priority queue unit
// Strict-priority pair of sixteen-entry FIFOs with an APB threshold register.
// ----------------------------------------------------------------------------
// An add word places its tag and key in the preferred queue when the key is
// at or above the threshold register (60 after reset), otherwise in the normal
// queue; an add to a full queue is dropped and reported as such. A serve word
// pops the preferred queue first and the normal queue only when the preferred
// one is empty, and reports an empty status when both are empty. Every input
// word yields exactly one result word carrying both fill counts after the
// step. Each queue keeps its entries in its own synchronous RAM, whose read
// data is ready in the cycle after the serve is taken; from there the result
// word passes into the result buffer. The unit takes one word per cycle as
// long as the result channel drains; a three-word result buffer lets it
// keep accepting while results wait, and it stalls the input whenever the
// words held in that buffer plus the word in the RAM read stage come to
// three, so that every accepted word is sure to find room. The threshold
// lives at byte address 0 and should be written only while the unit is idle.
module two_class_priority_queue_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input words
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tcpq_pkg::in_t                   s_data,
    // Result words
    output logic                            m_valid,
    input  logic                            m_ready,
    output tcpq_pkg::out_t                  m_data,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcpq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tcpq_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tcpq_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic [tcpq_pkg::KEY_BITS-1:0]  threshold_reg;
    logic [tcpq_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_write;
    logic [tcpq_pkg::RES_CNT_W-1:0] buf_count;
    tcpq_pkg::res_push_t            push;

    // Registers are word aligned; the index is the word address.
    assign reg_idx   = paddr[tcpq_pkg::APB_ADDR_W-1:2];
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= tcpq_pkg::THRESHOLD_RESET;
        end else if (cfg_write && reg_idx == tcpq_pkg::REG_THRESHOLD) begin
            threshold_reg <= pwdata[tcpq_pkg::KEY_BITS-1:0];
        end
    end

    // Unmapped addresses read as zero.
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            tcpq_pkg::REG_THRESHOLD: begin
                prdata = {{(tcpq_pkg::APB_DATA_W - tcpq_pkg::KEY_BITS){1'b0}}, threshold_reg};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // Queue bookkeeping, store RAMs and the read-data stage.
    tcpq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .threshold (threshold_reg),
        .buf_count (buf_count),
        .push      (push)
    );

    // Result words wait here until the result channel takes them.
    tcpq_res_buf u_res_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .count   (buf_count)
    );

endmodule
